FILE: hw/rtl/plar_pkg.sv
package plar_pkg;

  localparam int STROKE_DEPTH_DEF = 1024;
  localparam int OUT_LIMIT_DEF    = 128;
  localparam int COORD_BITS_DEF   = 24;

  localparam int LEN_BITS   = 36;
  localparam int CFG_BITS   = 8;
  localparam int T_FRAC     = 16;
  localparam int MIN_POINTS = 3;
  localparam int UNIT_LEN   = 256;

  localparam logic [CFG_BITS-1:0] MAX_POINTS_RESET = 8'd100;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ,
    F_SUM,
    F_ROOT,
    F_ACC,
    F_PUSH,
    F_WAIT
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_CLASS,
    B_TOTAL,
    B_NEXT,
    B_PT_RD,
    B_PT_GET,
    B_SEEK_RD,
    B_SEEK_MUL,
    B_SEEK_CMP,
    B_DIV_INIT,
    B_DIV,
    B_RD_A,
    B_RD_B,
    B_GET_B,
    B_LERP_MUL,
    B_LERP_FIN,
    B_PUSH,
    B_PASS
  } back_state_t;

  typedef struct packed {
    logic xy;
    logic cum;
  } wr_en_t;

endpackage

FILE: hw/rtl/plar_queue.sv
module plar_queue #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign push_ready = cnt != 2'd2;
  assign pop_valid  = cnt != 2'd0;
  assign pop_data   = slot[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");

endmodule

FILE: hw/rtl/plar_front.sv
module plar_front #(
  parameter int  DEPTH = 1024,
  parameter int  C     = 24,
  localparam int AW    = $clog2(DEPTH),
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [C-1:0]                  pt_x,
  input  logic [C-1:0]                  pt_y,
  input  logic                          last_point,
  input  logic                          back_busy,
  output logic                          job_valid,
  input  logic                          job_ready,
  output logic [NW-1:0]                 job_n,
  output plar_pkg::wr_en_t              wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [C-1:0]                  wr_x,
  output logic [C-1:0]                  wr_y,
  output logic [plar_pkg::LEN_BITS-1:0] wr_cum
);
  import plar_pkg::*;

  localparam int RB  = C + 1;
  localparam int RW  = C + 4;
  localparam int SW  = 2 * C + 2;
  localparam int ITW = $clog2(RB + 1);

  front_state_t        state;
  front_state_t        state_next;
  logic [NW-1:0]       count;
  logic [NW-1:0]       jn;
  logic [C-1:0]        cur_x;
  logic [C-1:0]        cur_y;
  logic [C-1:0]        prev_x;
  logic [C-1:0]        prev_y;
  logic [LEN_BITS-1:0] prev_cum;
  logic                lat_last;
  logic [2*C-1:0]      sq_x;
  logic [2*C-1:0]      sq_y;
  logic [SW-1:0]       rad;
  logic [RW-1:0]       rem;
  logic [C+1:0]        root;
  logic [ITW-1:0]      it;

  logic                accept;
  logic                full;
  logic signed [C:0]   dx;
  logic signed [C:0]   dy;
  logic [C:0]          ndx;
  logic [C:0]          ndy;
  logic [C-1:0]        adx;
  logic [C-1:0]        ady;
  logic [RW-1:0]       rem_sh;
  logic [RW-1:0]       trial;
  logic                ge;
  logic [C+1:0]        rounded;
  logic [LEN_BITS:0]   cum_sum;
  logic [LEN_BITS-1:0] cum_sat;

  assign accept  = in_valid && in_ready;
  assign full    = count == NW'(DEPTH);
  assign dx      = $signed({cur_x[C-1], cur_x}) - $signed({prev_x[C-1], prev_x});
  assign dy      = $signed({cur_y[C-1], cur_y}) - $signed({prev_y[C-1], prev_y});
  assign ndx     = -dx;
  assign ndy     = -dy;
  assign adx     = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ady     = dy[C] ? ndy[C-1:0] : dy[C-1:0];
  assign rem_sh  = {rem[RW-3:0], rad[SW-1:SW-2]};
  assign trial   = {root, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rounded = (rem > RW'(root)) ? root + (C+2)'(1) : root;
  assign cum_sum = {1'b0, prev_cum} + (LEN_BITS+1)'(rounded);
  assign cum_sat = cum_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : cum_sum[LEN_BITS-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (full || count == '0) begin
            state_next = last_point ? F_PUSH : F_IDLE;
          end else begin
            state_next = F_SQ;
          end
        end
      end
      F_SQ:   state_next = F_SUM;
      F_SUM:  state_next = F_ROOT;
      F_ROOT: begin
        if (it == ITW'(RB - 1)) begin
          state_next = F_ACC;
        end
      end
      F_ACC:  state_next = lat_last ? F_PUSH : F_IDLE;
      F_PUSH: begin
        if (job_ready) begin
          state_next = F_WAIT;
        end
      end
      F_WAIT: begin
        if (!back_busy) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = state == F_IDLE;
    job_valid  = state == F_PUSH;
    job_n      = jn;
    wr_en.xy   = accept && !full;
    wr_en.cum  = (accept && !full && count == '0) || state == F_ACC;
    wr_addr    = count[AW-1:0];
    wr_x       = pt_x;
    wr_y       = pt_y;
    wr_cum     = (state == F_ACC) ? cum_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && accept) begin
        if (full || count == '0) begin
          count <= last_point ? '0 : (full ? count : NW'(1));
        end
      end else if (state == F_ACC) begin
        count <= lat_last ? '0 : count + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          lat_last <= last_point;
          cur_x    <= pt_x;
          cur_y    <= pt_y;
          if (full) begin
            jn <= NW'(DEPTH);
          end else if (count == '0) begin
            prev_x   <= pt_x;
            prev_y   <= pt_y;
            prev_cum <= '0;
            jn       <= NW'(1);
          end
        end
      end
      F_SQ: begin
        sq_x <= adx * adx;
        sq_y <= ady * ady;
      end
      F_SUM: begin
        rad  <= SW'(sq_x) + SW'(sq_y);
        rem  <= '0;
        root <= '0;
        it   <= '0;
      end
      F_ROOT: begin
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[C:0], ge};
        rad  <= rad << 2;
        it   <= it + ITW'(1);
      end
      F_ACC: begin
        prev_x   <= cur_x;
        prev_y   <= cur_y;
        prev_cum <= cum_sat;
        jn       <= count + NW'(1);
      end
      F_PUSH, F_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("point count beyond store depth");

  a_wait_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == F_WAIT) |-> (count == '0))
    else $error("count not cleared after last point");

endmodule

FILE: hw/rtl/plar_back.sv
module plar_back #(
  parameter int  DEPTH     = 1024,
  parameter int  OUT_LIMIT = 128,
  parameter int  C         = 24,
  localparam int AW        = $clog2(DEPTH),
  localparam int NW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plar_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  logic [NW-1:0]                 job_n,
  input  plar_pkg::wr_en_t              wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [C-1:0]                  wr_x,
  input  logic [C-1:0]                  wr_y,
  input  logic [plar_pkg::LEN_BITS-1:0] wr_cum,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [C-1:0]                  a_x,
  output logic [C-1:0]                  a_y,
  output logic [C-1:0]                  b_x,
  output logic [C-1:0]                  b_y,
  output logic                          b_valid,
  output logic                          passthrough,
  output logic                          run_end
);
  import plar_pkg::*;

  localparam int MW  = $clog2(OUT_LIMIT + 1);
  localparam int CW  = (NW > MW) ? NW : MW;
  localparam int TW  = LEN_BITS + MW;
  localparam int QW  = T_FRAC + 1;
  localparam int DW  = TW + QW + 1;
  localparam int KW  = $clog2(QW);
  localparam int PW  = C + QW + 2;
  localparam int LW  = C + T_FRAC;

  logic [C-1:0]        mem_x   [DEPTH];
  logic [C-1:0]        mem_y   [DEPTH];
  logic [LEN_BITS-1:0] mem_cum [DEPTH];
  logic [C-1:0]        rd_x;
  logic [C-1:0]        rd_y;
  logic [LEN_BITS-1:0] rd_cum;
  logic [AW-1:0]       raddr;

  back_state_t         state;
  back_state_t         state_next;
  logic [CFG_BITS-1:0] max_points;
  logic [NW-1:0]       n;
  logic [MW-1:0]       m;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       p;
  logic                mode_rs;
  logic                have_a;
  logic [LEN_BITS-1:0] total;
  logic [TW-1:0]       tgt;
  logic [AW-1:0]       idx;
  logic [TW-1:0]       s0;
  logic [TW-1:0]       s1;
  logic [TW-1:0]       den;
  logic [TW-1:0]       num;
  logic [DW-1:0]       drem;
  logic [DW-1:0]       dsh;
  logic [QW-1:0]       q;
  logic [KW-1:0]       dk;
  logic [QW-1:0]       t;
  logic [C-1:0]        ax;
  logic [C-1:0]        ay;
  logic [C-1:0]        bx;
  logic [C-1:0]        by;
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic [C-1:0]        pt_xr;
  logic [C-1:0]        pt_yr;
  logic [C-1:0]        hold_x;
  logic [C-1:0]        hold_y;

  logic [MW-1:0]       steps;
  logic [CFG_BITS-1:0] m_clamp;
  logic                echo;
  logic                last_pt;
  logic                interp;
  logic                adv;
  logic [TW-1:0]       den_c;
  logic [TW-1:0]       num_c;
  logic                div_ge;
  logic signed [C:0]   dxl;
  logic signed [C:0]   dyl;
  logic [LW-1:0]       vx;
  logic [LW-1:0]       vy;
  logic                out_free;
  logic                load_pair;
  logic                load_pass;
  logic [AW-1:0]       ptaddr;

  always_ff @(posedge clk) begin
    if (wr_en.xy) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    if (wr_en.cum) begin
      mem_cum[wr_addr] <= wr_cum;
    end
    rd_x   <= mem_x[raddr];
    rd_y   <= mem_y[raddr];
    rd_cum <= mem_cum[raddr];
  end

  assign cfg_ready = 1'b1;
  assign steps     = m - MW'(1);
  assign m_clamp   = (max_points < CFG_BITS'(MIN_POINTS)) ? CFG_BITS'(MIN_POINTS) :
                     (max_points > CFG_BITS'(OUT_LIMIT)) ? CFG_BITS'(OUT_LIMIT) : max_points;
  assign echo      = (n <= NW'(2)) || (CW'(n) <= CW'(m));
  assign last_pt   = p == cnt - CW'(1);
  assign interp    = mode_rs && p != '0 && !last_pt;
  assign adv       = (NW'(idx) + NW'(1) < n) && (s1 < tgt);
  assign den_c     = (s1 > s0) ? s1 - s0 : '0;
  assign num_c     = (tgt > s0) ? tgt - s0 : '0;
  assign div_ge    = drem >= dsh;
  assign dxl       = $signed({bx[C-1], bx}) - $signed({ax[C-1], ax});
  assign dyl       = $signed({by[C-1], by}) - $signed({ay[C-1], ay});
  assign vx        = {ax, {T_FRAC{1'b0}}} + prod_x[LW-1:0] + LW'(1 << (T_FRAC - 1));
  assign vy        = {ay, {T_FRAC{1'b0}}} + prod_y[LW-1:0] + LW'(1 << (T_FRAC - 1));
  assign out_free  = !out_valid || out_ready;
  assign load_pair = state == B_PUSH && (have_a || last_pt) && out_free;
  assign load_pass = state == B_PASS && out_free;
  assign ptaddr    = !mode_rs ? AW'(p) : (p == '0 ? '0 : AW'(n - NW'(1)));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = B_CLASS;
        end
      end
      B_CLASS: begin
        if (n == '0) begin
          state_next = B_PASS;
        end else if (echo) begin
          state_next = B_NEXT;
        end else begin
          state_next = B_TOTAL;
        end
      end
      B_TOTAL:    state_next = (rd_cum < LEN_BITS'(UNIT_LEN)) ? B_PASS : B_NEXT;
      B_NEXT:     state_next = interp ? B_SEEK_RD : B_PT_RD;
      B_PT_RD:    state_next = B_PT_GET;
      B_PT_GET:   state_next = B_PUSH;
      B_SEEK_RD:  state_next = B_SEEK_MUL;
      B_SEEK_MUL: state_next = B_SEEK_CMP;
      B_SEEK_CMP: state_next = adv ? B_SEEK_RD : B_DIV_INIT;
      B_DIV_INIT: state_next = B_DIV;
      B_DIV: begin
        if (dk == '0) begin
          state_next = B_RD_A;
        end
      end
      B_RD_A:     state_next = B_RD_B;
      B_RD_B:     state_next = B_GET_B;
      B_GET_B:    state_next = B_LERP_MUL;
      B_LERP_MUL: state_next = B_LERP_FIN;
      B_LERP_FIN: state_next = B_PUSH;
      B_PUSH: begin
        if (have_a || last_pt) begin
          if (out_free) begin
            state_next = last_pt ? B_IDLE : B_NEXT;
          end
        end else begin
          state_next = B_NEXT;
        end
      end
      B_PASS: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    idle      = state == B_IDLE;
    job_ready = state == B_IDLE;
    unique case (state)
      B_CLASS:   raddr = AW'(n - NW'(1));
      B_PT_RD:   raddr = ptaddr;
      B_SEEK_RD: raddr = idx;
      B_RD_A:    raddr = idx - AW'(1);
      B_RD_B:    raddr = idx;
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      max_points <= MAX_POINTS_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        max_points <= cfg_data;
      end
      if (load_pair || load_pass) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pass) begin
      a_x         <= '0;
      a_y         <= '0;
      b_x         <= '0;
      b_y         <= '0;
      b_valid     <= 1'b0;
      passthrough <= 1'b1;
      run_end     <= 1'b1;
    end else if (load_pair) begin
      a_x         <= have_a ? hold_x : pt_xr;
      a_y         <= have_a ? hold_y : pt_yr;
      b_x         <= have_a ? pt_xr : '0;
      b_y         <= have_a ? pt_yr : '0;
      b_valid     <= have_a;
      passthrough <= 1'b0;
      run_end     <= last_pt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          n <= job_n;
          m <= MW'(m_clamp);
        end
      end
      B_CLASS: begin
        cnt     <= CW'(n);
        p       <= '0;
        have_a  <= 1'b0;
        mode_rs <= 1'b0;
      end
      B_TOTAL: begin
        total   <= rd_cum;
        cnt     <= CW'(m);
        p       <= '0;
        have_a  <= 1'b0;
        mode_rs <= 1'b1;
        tgt     <= '0;
        idx     <= AW'(1);
        s0      <= '0;
      end
      B_NEXT: begin
        if (interp) begin
          tgt <= tgt + TW'(total);
        end
      end
      B_PT_GET: begin
        pt_xr <= rd_x;
        pt_yr <= rd_y;
      end
      B_SEEK_MUL: begin
        s1 <= TW'(rd_cum) * TW'(steps);
      end
      B_SEEK_CMP: begin
        if (adv) begin
          s0  <= s1;
          idx <= idx + AW'(1);
        end else begin
          den <= den_c;
          num <= (num_c > den_c) ? den_c : num_c;
        end
      end
      B_DIV_INIT: begin
        drem <= DW'({num, {QW{1'b0}}}) + DW'(den);
        dsh  <= DW'(den) << (QW);
        q    <= '0;
        dk   <= KW'(QW - 1);
      end
      B_DIV: begin
        if (div_ge) begin
          drem <= drem - dsh;
        end
        q   <= {q[QW-2:0], div_ge};
        dsh <= dsh >> 1;
        dk  <= dk - KW'(1);
      end
      B_RD_A: begin
        if (den == '0) begin
          t <= '0;
        end else if (q > QW'(1 << T_FRAC)) begin
          t <= QW'(1 << T_FRAC);
        end else begin
          t <= q;
        end
      end
      B_RD_B: begin
        ax <= rd_x;
        ay <= rd_y;
      end
      B_GET_B: begin
        bx <= rd_x;
        by <= rd_y;
      end
      B_LERP_MUL: begin
        prod_x <= dxl * $signed({1'b0, t});
        prod_y <= dyl * $signed({1'b0, t});
      end
      B_LERP_FIN: begin
        pt_xr <= vx[LW-1:T_FRAC];
        pt_yr <= vy[LW-1:T_FRAC];
      end
      B_PUSH: begin
        if (have_a || last_pt) begin
          if (out_free && !last_pt) begin
            p      <= p + CW'(1);
            have_a <= 1'b0;
          end
        end else begin
          hold_x <= pt_xr;
          hold_y <= pt_yr;
          have_a <= 1'b1;
          p      <= p + CW'(1);
        end
      end
      B_PT_RD, B_SEEK_RD, B_PASS: begin
      end
      default: begin
      end
    endcase
  end

  a_point_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == B_PUSH) |-> (p < cnt))
    else $error("point index past end of run");

  a_seek_in_stroke: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEEK_CMP) |-> (idx != '0 && NW'(idx) < n))
    else $error("segment index outside stroke");

endmodule

FILE: hw/rtl/polyline_arc_length_resampler.sv
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     pt_x, pt_y, last_point
// out      out  out_valid/out_ready   a_x, a_y, b_x, b_y, b_valid, passthrough, run_end
// cfg      in   cfg_valid/cfg_ready   cfg_data (max_points)
//
// each stored point after the first of a stroke goes through the bit-per-cycle square root
// a resampled output point walks the stroke segments up to its target, then runs the 17-step
// divider for t; echoed points are read straight from the point store
// results wait in an output register; no new point is taken until the last run is generated
// synchronous reset clears control state and sets max_points to 100; no clearing pass
module polyline_arc_length_resampler #(
  parameter int STROKE_DEPTH = plar_pkg::STROKE_DEPTH_DEF,
  parameter int OUT_LIMIT    = plar_pkg::OUT_LIMIT_DEF,
  parameter int COORD_BITS   = plar_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plar_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         pt_x,
  input  logic [COORD_BITS-1:0]         pt_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         a_x,
  output logic [COORD_BITS-1:0]         a_y,
  output logic [COORD_BITS-1:0]         b_x,
  output logic [COORD_BITS-1:0]         b_y,
  output logic                          b_valid,
  output logic                          passthrough,
  output logic                          run_end
);
  import plar_pkg::*;

  localparam int AW = $clog2(STROKE_DEPTH);
  localparam int NW = $clog2(STROKE_DEPTH + 1);

  logic                  job_push_valid;
  logic                  job_push_ready;
  logic [NW-1:0]         job_push_n;
  logic                  job_pop_valid;
  logic                  job_pop_ready;
  logic [NW-1:0]         job_pop_n;
  logic                  back_idle;
  logic                  back_busy;
  wr_en_t                wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COORD_BITS-1:0] wr_x;
  logic [COORD_BITS-1:0] wr_y;
  logic [LEN_BITS-1:0]   wr_cum;

  assign back_busy = job_pop_valid || !back_idle;

  plar_front #(
    .DEPTH (STROKE_DEPTH),
    .C     (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .last_point (last_point),
    .back_busy  (back_busy),
    .job_valid  (job_push_valid),
    .job_ready  (job_push_ready),
    .job_n      (job_push_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_x       (wr_x),
    .wr_y       (wr_y),
    .wr_cum     (wr_cum)
  );

  plar_queue #(
    .W (NW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push_n),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop_n)
  );

  plar_back #(
    .DEPTH     (STROKE_DEPTH),
    .OUT_LIMIT (OUT_LIMIT),
    .C         (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .job_valid   (job_pop_valid),
    .job_ready   (job_pop_ready),
    .job_n       (job_pop_n),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_x        (wr_x),
    .wr_y        (wr_y),
    .wr_cum      (wr_cum),
    .idle        (back_idle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .a_x         (a_x),
    .a_y         (a_y),
    .b_x         (b_x),
    .b_y         (b_y),
    .b_valid     (b_valid),
    .passthrough (passthrough),
    .run_end     (run_end)
  );

endmodule
